[rtl/cslq_pkg.sv]
`timescale 1ns / 1ps
package cslq_pkg;

	localparam int HANDLE_W = 8;
	localparam int CMD_TAG_W = 16;
	localparam int LIMIT_W = 5;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
	localparam logic [HANDLE_W-1:0] HANDLE_RESERVED = 8'd0;

	typedef enum logic [1:0] {
		OP_ENQUEUE  = 2'd0,
		OP_CANCEL   = 2'd1,
		OP_DISPATCH = 2'd2,
		OP_ACK      = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STATUS_OK        = 3'd0,
		STATUS_NO_SPACE  = 3'd1,
		STATUS_NOT_FOUND = 3'd2,
		STATUS_REFUSED   = 3'd3,
		STATUS_EMPTY     = 3'd4,
		STATUS_BUSY      = 3'd5
	} status_t;

	typedef struct packed {
		op_t                  operation;
		logic [HANDLE_W-1:0]  target_handle;
		logic [CMD_TAG_W-1:0] command_tag;
		logic                 tx_accepted;
	} in_item_t;

	typedef struct packed {
		status_t              status;
		logic [HANDLE_W-1:0]  slot_handle;
		logic [CMD_TAG_W-1:0] slot_tag;
		logic                 kick;
	} out_item_t;

	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_DECIDE = 2'd1,
		S_WALK   = 2'd2,
		S_POP    = 2'd3
	} fsm_t;

	typedef enum logic [3:0] {
		RES_ENQ_FULL        = 4'd0,
		RES_ENQ_OK          = 4'd1,
		RES_CANCEL_INFLIGHT = 4'd2,
		RES_CANCEL_QUEUED   = 4'd3,
		RES_NOT_FOUND       = 4'd4,
		RES_BUSY            = 4'd5,
		RES_EMPTY           = 4'd6,
		RES_DISPATCH        = 4'd7,
		RES_ACK             = 4'd8
	} res_t;

	typedef struct packed {
		logic latch_item;
		logic enq_write;
		logic inflight_clear;
		logic walk_start;
		logic walk_step;
		logic walk_finish;
		logic head_read;
		logic pop;
		logic res_load;
		res_t res_sel;
	} dp_ctl_t;

	typedef struct packed {
		op_t  operation;
		logic full;
		logic inflight_valid;
		logic inflight_match;
		logic queue_empty;
		logic walk_done;
		logic found;
		logic rsp_free;
	} dp_stat_t;

endpackage

[rtl/cslq_if.sv]
`timescale 1ns / 1ps
interface cslq_cmd_if;
	logic               valid;
	logic               ready;
	cslq_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cslq_rsp_if;
	logic                valid;
	logic                ready;
	cslq_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cslq_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [cslq_pkg::LIMIT_W-1:0]     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/cslq_ctrl.sv]
`timescale 1ns / 1ps
module cslq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  cslq_pkg::dp_stat_t stat,
	output cslq_pkg::dp_ctl_t  ctl
);
	import cslq_pkg::*;

	fsm_t state_q;
	fsm_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (stat.operation == OP_CANCEL && !stat.inflight_match && !stat.queue_empty) begin
					state_d = S_WALK;
				end else if (stat.operation == OP_DISPATCH && !stat.inflight_valid
						&& !stat.queue_empty) begin
					state_d = S_POP;
				end else if (stat.rsp_free) begin
					state_d = S_IDLE;
				end
			end
			S_WALK: begin
				if (stat.walk_done && stat.rsp_free) begin
					state_d = S_IDLE;
				end
			end
			S_POP: begin
				if (stat.rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		ctl = '0;
		ctl.res_sel = RES_NOT_FOUND;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				ctl.latch_item = in_valid;
			end
			S_DECIDE: begin
				unique case (stat.operation)
					OP_ENQUEUE: begin
						ctl.res_load = stat.rsp_free;
						if (stat.full) begin
							ctl.res_sel = RES_ENQ_FULL;
						end else begin
							ctl.res_sel = RES_ENQ_OK;
							ctl.enq_write = stat.rsp_free;
						end
					end
					OP_CANCEL: begin
						if (stat.inflight_match) begin
							ctl.res_sel = RES_CANCEL_INFLIGHT;
							ctl.res_load = stat.rsp_free;
							ctl.inflight_clear = stat.rsp_free;
						end else if (stat.queue_empty) begin
							ctl.res_sel = RES_NOT_FOUND;
							ctl.res_load = stat.rsp_free;
						end else begin
							ctl.walk_start = 1'b1;
						end
					end
					OP_DISPATCH: begin
						if (stat.inflight_valid) begin
							ctl.res_sel = RES_BUSY;
							ctl.res_load = stat.rsp_free;
						end else if (stat.queue_empty) begin
							ctl.res_sel = RES_EMPTY;
							ctl.res_load = stat.rsp_free;
						end else begin
							ctl.head_read = 1'b1;
						end
					end
					OP_ACK: begin
						ctl.res_sel = RES_ACK;
						ctl.res_load = stat.rsp_free;
						ctl.inflight_clear = stat.rsp_free;
					end
					default: ctl.res_sel = RES_NOT_FOUND;
				endcase
			end
			S_WALK: begin
				if (stat.walk_done) begin
					ctl.res_sel = stat.found ? RES_CANCEL_QUEUED : RES_NOT_FOUND;
					ctl.res_load = stat.rsp_free;
					ctl.walk_finish = stat.rsp_free;
				end else begin
					ctl.walk_step = 1'b1;
				end
			end
			S_POP: begin
				ctl.res_sel = RES_DISPATCH;
				ctl.res_load = stat.rsp_free;
				ctl.pop = stat.rsp_free;
			end
			default: ctl.res_sel = RES_NOT_FOUND;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.res_load |-> stat.rsp_free)
		else $error("result loaded over an untaken result");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK && !stat.walk_done) |=> state_q == S_WALK)
		else $error("queue walk left before it was done");

	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.head_read |=> state_q == S_POP)
		else $error("head read without a pop to follow");

endmodule

[rtl/cslq_dp.sv]
`timescale 1ns / 1ps
module cslq_dp #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TAG_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cslq_pkg::in_item_t           in_data,
	input  logic                         cfg_valid,
	input  logic [cslq_pkg::LIMIT_W-1:0] cfg_data,
	input  cslq_pkg::dp_ctl_t            ctl,
	input  logic                         rsp_ready,
	output logic                         rsp_valid,
	output cslq_pkg::out_item_t          rsp_data,
	output cslq_pkg::dp_stat_t           stat
);
	import cslq_pkg::*;

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = HANDLE_W + TAG_WIDTH;
	localparam int UW = 10;

	function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
			input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW+1)'(base) + (CW+1)'(off);
		if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
			sum = sum - (CW+1)'(QUEUE_DEPTH);
		end
		return sum[IW-1:0];
	endfunction

	in_item_t            item_q;
	logic [LIMIT_W-1:0]  slot_limit_q;
	logic [CW-1:0]       count_q;
	logic [IW-1:0]       head_q;
	logic [HANDLE_W-1:0] last_handle_q;
	logic                inflight_valid_q;
	logic [HANDLE_W-1:0] inflight_handle_q;
	logic [TAG_WIDTH-1:0] inflight_tag_q;
	logic [CW-1:0]       rd_idx_q;
	logic                chk_valid_s1;
	logic [CW-1:0]       chk_pos_s1;
	logic                found_q;
	logic                rsp_valid_q;
	out_item_t           rsp_q;

	logic [SW-1:0]       mem_q [QUEUE_DEPTH];
	logic [SW-1:0]       mem_rdata_q;

	logic [HANDLE_W-1:0] rd_handle;
	logic [TAG_WIDTH-1:0] rd_tag;
	logic [TAG_WIDTH-1:0] new_tag;
	logic [HANDLE_W-1:0] nh_raw;
	logic [HANDLE_W-1:0] new_handle;
	logic [UW-1:0]       used;
	logic                full;
	logic                rd_more;
	logic                walk_rd;
	logic                walk_wr;
	logic                mem_we;
	logic                mem_re;
	logic [IW-1:0]       mem_waddr;
	logic [IW-1:0]       mem_raddr;
	logic [SW-1:0]       mem_wdata;
	out_item_t           res_d;

	assign rd_handle = mem_rdata_q[SW-1 -: HANDLE_W];
	assign rd_tag    = mem_rdata_q[TAG_WIDTH-1:0];
	assign new_tag   = TAG_WIDTH'(32'(item_q.command_tag));
	assign nh_raw    = last_handle_q + 8'd1;
	assign new_handle = (nh_raw == HANDLE_RESERVED) ? nh_raw + 8'd1 : nh_raw;

	assign used = UW'(count_q) + UW'(inflight_valid_q);
	assign full = (used >= UW'(slot_limit_q)) || (used >= UW'(QUEUE_DEPTH));

	assign rd_more = rd_idx_q < count_q;
	assign walk_rd = ctl.walk_step && rd_more;
	assign walk_wr = ctl.walk_step && chk_valid_s1 && found_q;

	// slot memory ports
	always_comb begin
		mem_we    = ctl.enq_write || walk_wr;
		mem_waddr = ctl.enq_write ? wrap_add(head_q, count_q)
			: wrap_add(head_q, chk_pos_s1 - CW'(1));
		mem_wdata = ctl.enq_write ? {new_handle, new_tag} : mem_rdata_q;
		mem_re    = ctl.head_read || walk_rd;
		mem_raddr = ctl.head_read ? head_q : wrap_add(head_q, rd_idx_q);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= mem_q[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch_item) begin
			item_q <= in_data;
		end
		if (ctl.res_load) begin
			rsp_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_limit_q      <= LIMIT_RESET;
			count_q           <= '0;
			head_q            <= '0;
			last_handle_q     <= HANDLE_RESERVED;
			inflight_valid_q  <= 1'b0;
			inflight_handle_q <= '0;
			inflight_tag_q    <= '0;
			rd_idx_q          <= '0;
			chk_valid_s1      <= 1'b0;
			chk_pos_s1        <= '0;
			found_q           <= 1'b0;
			rsp_valid_q       <= 1'b0;
		end else begin
			if (cfg_valid) begin
				slot_limit_q <= cfg_data;
			end

			if (ctl.enq_write) begin
				count_q       <= count_q + CW'(1);
				last_handle_q <= new_handle;
			end else if (ctl.pop || (ctl.walk_finish && found_q)) begin
				count_q <= count_q - CW'(1);
			end

			if (ctl.pop) begin
				head_q <= wrap_add(head_q, CW'(1));
			end

			if (ctl.inflight_clear) begin
				inflight_valid_q  <= 1'b0;
				inflight_handle_q <= '0;
				inflight_tag_q    <= '0;
			end else if (ctl.pop && item_q.tx_accepted) begin
				inflight_valid_q  <= 1'b1;
				inflight_handle_q <= rd_handle;
				inflight_tag_q    <= rd_tag;
			end

			// search and close the gap in one pass over the queue
			if (ctl.walk_start) begin
				rd_idx_q     <= '0;
				chk_valid_s1 <= 1'b0;
				found_q      <= 1'b0;
			end else if (ctl.walk_step) begin
				chk_valid_s1 <= rd_more;
				if (rd_more) begin
					rd_idx_q   <= rd_idx_q + CW'(1);
					chk_pos_s1 <= rd_idx_q;
				end
				if (chk_valid_s1 && !found_q && rd_handle == item_q.target_handle) begin
					found_q <= 1'b1;
				end
			end

			if (ctl.res_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		res_d = '0;
		res_d.status = STATUS_OK;
		case (ctl.res_sel)
			RES_ENQ_FULL: res_d.status = STATUS_NO_SPACE;
			RES_ENQ_OK: begin
				res_d.slot_handle = new_handle;
				res_d.kick = !inflight_valid_q;
			end
			RES_CANCEL_INFLIGHT: begin
				res_d.slot_handle = item_q.target_handle;
				res_d.kick = count_q != '0;
			end
			RES_CANCEL_QUEUED: res_d.slot_handle = item_q.target_handle;
			RES_NOT_FOUND: res_d.status = STATUS_NOT_FOUND;
			RES_BUSY: res_d.status = STATUS_BUSY;
			RES_EMPTY: res_d.status = STATUS_EMPTY;
			RES_DISPATCH: begin
				res_d.status = item_q.tx_accepted ? STATUS_OK : STATUS_REFUSED;
				res_d.slot_handle = rd_handle;
				res_d.slot_tag = CMD_TAG_W'(32'(rd_tag));
				res_d.kick = !item_q.tx_accepted && (count_q > CW'(1));
			end
			RES_ACK: begin
				res_d.kick = count_q != '0;
				if (inflight_valid_q) begin
					res_d.slot_handle = inflight_handle_q;
					res_d.slot_tag = CMD_TAG_W'(32'(inflight_tag_q));
				end else begin
					res_d.status = STATUS_NOT_FOUND;
				end
			end
			default: res_d.status = STATUS_NOT_FOUND;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	always_comb begin
		stat.operation      = item_q.operation;
		stat.full           = full;
		stat.inflight_valid = inflight_valid_q;
		stat.inflight_match = inflight_valid_q && (inflight_handle_q == item_q.target_handle);
		stat.queue_empty    = count_q == '0;
		stat.walk_done      = !chk_valid_s1 && !rd_more;
		stat.found          = found_q;
		stat.rsp_free       = !rsp_valid_q || rsp_ready;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.enq_write |=> count_q == $past(count_q) + CW'(1))
		else $error("enqueue did not grow the queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(inflight_valid_q) |-> $past(ctl.pop && item_q.tx_accepted))
		else $error("in-flight slot set without an accepted dispatch");

	assert property (@(posedge clk) disable iff (!arst_n)
		walk_wr |-> (mem_waddr != mem_raddr || !walk_rd))
		else $error("walk wrote the entry it was reading");

endmodule

[rtl/command_slot_queue_with_cancel.sv]
`timescale 1ns / 1ps
// Queue of command slots with one command in flight. Each command beat is one of enqueue,
// cancel, dispatch head or acknowledge, and gives exactly one response beat. Enqueue,
// acknowledge, a cancel that hits the in-flight slot or finds the queue empty, and a dispatch
// that reports busy or empty load their result from the DECIDE state; a dispatch that pops the
// head loads it from the POP state, after the registered read of the head slot. A cancel that
// misses the in-flight slot with slots queued walks the queue through the single read port of
// the slot memory, one slot a cycle, finding and closing the gap in the same pass. One command
// is worked on at a time; the next one is taken while a finished response still waits. The user
// must write the slot limit on cfg only while the block is idle; the block does not enforce it.
module command_slot_queue_with_cancel #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TAG_WIDTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	cslq_cmd_if.sink   cmd,
	cslq_rsp_if.source rsp,
	cslq_cfg_if.sink   cfg
);
	import cslq_pkg::*;

	dp_ctl_t  ctl;
	dp_stat_t stat;
	logic     in_ready;

	assign cmd.ready = in_ready;
	assign cfg.ready = 1'b1;

	cslq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	cslq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TAG_WIDTH   (TAG_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (cmd.data),
		.cfg_valid (cfg.valid),
		.cfg_data  (cfg.data),
		.ctl       (ctl),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.rsp_data  (rsp.data),
		.stat      (stat)
	);

endmodule
